[src/fcom_pkg.sv]
// Package: shared constants, types and tables for the fly camera block.
package fcom_pkg;

   localparam int PositionWidthDefault  = 32;
   localparam int TrigIterationsDefault = 14;
   localparam int AtanCount             = 20;

   localparam logic [1:0] OP_LOOK = 2'd0;
   localparam logic [1:0] OP_KEY  = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   localparam logic CSR_SENS  = 1'b0;
   localparam logic CSR_SPEED = 1'b1;

   localparam logic [15:0] SENS_RESET  = 16'd6554;
   localparam logic [15:0] SPEED_RESET = 16'd640;

   localparam logic signed [15:0] HEAD_HALF  = 16'sd23040;
   localparam logic signed [17:0] HEAD_FULL  = 18'sd46080;
   localparam logic signed [17:0] TILT_LIMIT = 18'sd11392;
   localparam logic signed [15:0] UNIT_Q14   = 16'sd16384;
   localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

   // Datapath commands issued by the controller
   localparam logic [2:0] CMD_NONE   = 3'd0;
   localparam logic [2:0] CMD_LOAD   = 3'd1;
   localparam logic [2:0] CMD_ANGLE  = 3'd2;
   localparam logic [2:0] CMD_CINIT  = 3'd3;
   localparam logic [2:0] CMD_CITER  = 3'd4;
   localparam logic [2:0] CMD_CDONE  = 3'd5;
   localparam logic [2:0] CMD_VEC    = 3'd6;
   localparam logic [2:0] CMD_MOVE   = 3'd7;

   typedef struct packed {
      logic [2:0] cmd;
      logic       sel_tilt;   // cordic works on tilt when set
      logic [4:0] iter;       // cordic round, or move phase
      logic [2:0] dir;        // movement direction in progress
      logic [1:0] axis;       // movement axis in progress
   } ctl_type;

   function automatic logic signed [22:0] atan_lookup(input logic [4:0] idx);
      logic signed [22:0] v;
      case (idx)
         5'd0:  v = 23'sd2949120;
         5'd1:  v = 23'sd1740967;
         5'd2:  v = 23'sd919879;
         5'd3:  v = 23'sd466945;
         5'd4:  v = 23'sd234379;
         5'd5:  v = 23'sd117304;
         5'd6:  v = 23'sd58666;
         5'd7:  v = 23'sd29334;
         5'd8:  v = 23'sd14668;
         5'd9:  v = 23'sd7334;
         5'd10: v = 23'sd3667;
         5'd11: v = 23'sd1833;
         5'd12: v = 23'sd917;
         5'd13: v = 23'sd458;
         5'd14: v = 23'sd229;
         5'd15: v = 23'sd115;
         5'd16: v = 23'sd57;
         5'd17: v = 23'sd29;
         5'd18: v = 23'sd14;
         5'd19: v = 23'sd7;
         default: v = 23'sd0;
      endcase
      return v;
   endfunction

endpackage

[src/fly_camera_orientation_motion_top.sv]
// Top level: free-fly camera orientation and motion block.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall| op, look_dx/dy, direction_index, key_down, dt
//   rsp     | out       | rsp_valid/rsp_stall| pos_x/y/z, front_x/y/z, heading_out, tilt_out
//   csr     | in        | csr_write          | csr_index, csr_data
//
// A look item runs one shared CORDIC unit for heading, then tilt.
// A tick item works through each held direction, one multiplier shared over axes.
// Reset is synchronous; state returns to its reset values.
// A stalled result holds in its register; the next item is taken once it leaves.
module fly_camera_orientation_motion_top import fcom_pkg::*; #(
   parameter int POSITION_WIDTH  = PositionWidthDefault,
   parameter int TRIG_ITERATIONS = TrigIterationsDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_op,
   input  logic signed [15:0]               req_look_dx,
   input  logic signed [15:0]               req_look_dy,
   input  logic [2:0]                       req_direction_index,
   input  logic                             req_key_down,
   input  logic [15:0]                      req_delta_time,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [31:0]               rsp_pos_x,
   output logic signed [31:0]               rsp_pos_y,
   output logic signed [31:0]               rsp_pos_z,
   output logic signed [15:0]               rsp_front_x,
   output logic signed [15:0]               rsp_front_y,
   output logic signed [15:0]               rsp_front_z,
   output logic signed [15:0]               rsp_heading_out,
   output logic signed [14:0]               rsp_tilt_out,
   input  logic                             csr_write,
   input  logic [1:0]                       csr_index,
   input  logic [15:0]                      csr_data
);

   ctl_type ctl;
   logic [5:0] held;
   logic signed [POSITION_WIDTH-1:0] px, py, pz;

   fcom_ctrl #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .held      (held),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   fcom_dpath #(.POSITION_WIDTH(POSITION_WIDTH)) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .csr_write           (csr_write),
      .csr_index           (csr_index[0]),
      .csr_index_ok        (!csr_index[1]),
      .csr_data            (csr_data),
      .req_op              (req_op),
      .req_look_dx         (req_look_dx),
      .req_look_dy         (req_look_dy),
      .req_direction_index (req_direction_index),
      .req_key_down        (req_key_down),
      .req_delta_time      (req_delta_time),
      .held                (held),
      .pos_x               (px),
      .pos_y               (py),
      .pos_z               (pz),
      .front_x             (rsp_front_x),
      .front_y             (rsp_front_y),
      .front_z             (rsp_front_z),
      .heading             (rsp_heading_out),
      .tilt                (rsp_tilt_out)
   );

   // Present the low 32 bits of the position, sign-extended when narrower
   assign rsp_pos_x = 32'(px);
   assign rsp_pos_y = 32'(py);
   assign rsp_pos_z = 32'(pz);

`ifndef SYNTH
   // no item taken while a result waits
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("item accepted while result stalled");
   // a stalled result keeps its heading
   a_hold_heading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_heading_out))
      else $error("heading changed under stall");
   // tilt stays within its clamp
   a_tilt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tilt_out <= 15'sd11392 && rsp_tilt_out >= -15'sd11392)
      else $error("tilt out of range");
`endif

endmodule

[src/fcom_ctrl.sv]
// Controller: sequences look, key and tick items over the datapath.
module fcom_ctrl import fcom_pkg::*; #(
   parameter int TRIG_ITERATIONS = TrigIterationsDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [5:0] held,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output ctl_type    ctl
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ANGLE = 4'd1;
   localparam logic [3:0] S_CINIT = 4'd2;
   localparam logic [3:0] S_CITER = 4'd3;
   localparam logic [3:0] S_CDONE = 4'd4;
   localparam logic [3:0] S_VEC   = 4'd5;
   localparam logic [3:0] S_MOVE  = 4'd6;
   localparam logic [3:0] S_DONE  = 4'd7;
   localparam logic [4:0] ITER_LAST = 5'(TRIG_ITERATIONS - 1);

   logic [3:0] state_ff, state_in;
   logic       tilt_ff, tilt_in;
   logic [4:0] iter_ff, iter_in;
   logic [2:0] dir_ff, dir_in;
   logic [1:0] axis_ff, axis_in;
   logic       phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       busy;
   logic [2:0] first_dir;
   logic [2:0] next_dir;
   logic       any_next;

   // Movement order: left, right, down, up, backward, forward
   function automatic logic [2:0] order_dir(input logic [2:0] slot);
      logic [2:0] d;
      case (slot)
         3'd0: d = 3'd0;
         3'd1: d = 3'd1;
         3'd2: d = 3'd2;
         3'd3: d = 3'd3;
         3'd4: d = 3'd5;
         default: d = 3'd4;
      endcase
      return d;
   endfunction

   // Find next held direction slot after dir_ff (slot index)
   always_comb begin
      next_dir = 3'd0;
      any_next = 1'b0;
      for (int s = 5; s >= 0; s--) begin
         if (3'(s) > dir_ff && held[order_dir(3'(s))]) begin
            next_dir = 3'(s);
            any_next = 1'b1;
         end
      end
      first_dir = 3'd0;
      for (int s = 5; s >= 0; s--) begin
         if (held[order_dir(3'(s))]) begin
            first_dir = 3'(s);
         end
      end
   end

   assign busy      = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      tilt_in      = tilt_ff;
      iter_in      = iter_ff;
      dir_in       = dir_ff;
      axis_in      = axis_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctl.cmd      = CMD_NONE;
      ctl.sel_tilt = tilt_ff;
      ctl.iter     = iter_ff;
      ctl.dir      = order_dir(dir_ff);
      ctl.axis     = axis_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ctl.cmd = CMD_LOAD;
               if (req_op == OP_LOOK) begin
                  state_in = S_ANGLE;
               end else if (req_op == OP_TICK && held != 6'd0) begin
                  state_in = S_MOVE;
                  dir_in   = first_dir;
                  axis_in  = 2'd0;
                  phase_in = 1'b0;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_ANGLE: begin
            ctl.cmd  = CMD_ANGLE;
            tilt_in  = 1'b0;
            state_in = S_CINIT;
         end
         S_CINIT: begin
            ctl.cmd  = CMD_CINIT;
            iter_in  = 5'd0;
            state_in = S_CITER;
         end
         S_CITER: begin
            ctl.cmd = CMD_CITER;
            iter_in = iter_ff + 5'd1;
            if (iter_ff == ITER_LAST) begin
               state_in = S_CDONE;
            end
         end
         S_CDONE: begin
            ctl.cmd = CMD_CDONE;
            if (tilt_ff) begin
               state_in = S_VEC;
            end else begin
               tilt_in  = 1'b1;
               state_in = S_CINIT;
            end
         end
         S_VEC: begin
            ctl.cmd  = CMD_VEC;
            state_in = S_DONE;
         end
         S_MOVE: begin
            // two phases per axis: multiply, then saturating add
            ctl.cmd  = CMD_MOVE;
            ctl.iter = {4'd0, phase_ff};
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (axis_ff == 2'd2) begin
                  axis_in = 2'd0;
                  if (any_next) begin
                     dir_in = next_dir;
                  end else begin
                     state_in = S_DONE;
                  end
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tilt_ff      <= 1'b0;
         iter_ff      <= 5'd0;
         dir_ff       <= 3'd0;
         axis_ff      <= 2'd0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tilt_ff      <= tilt_in;
         iter_ff      <= iter_in;
         dir_ff       <= dir_in;
         axis_ff      <= axis_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[src/fcom_dpath.sv]
// Datapath: angles, CORDIC sine/cosine, vectors and position.
module fcom_dpath import fcom_pkg::*; #(
   parameter int POSITION_WIDTH = PositionWidthDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ctl_type                          ctl,
   input  logic                             csr_write,
   input  logic                             csr_index,
   input  logic                             csr_index_ok,
   input  logic [15:0]                      csr_data,
   input  logic [1:0]                       req_op,
   input  logic signed [15:0]               req_look_dx,
   input  logic signed [15:0]               req_look_dy,
   input  logic [2:0]                       req_direction_index,
   input  logic                             req_key_down,
   input  logic [15:0]                      req_delta_time,
   output logic [5:0]                       held,
   output logic signed [POSITION_WIDTH-1:0] pos_x,
   output logic signed [POSITION_WIDTH-1:0] pos_y,
   output logic signed [POSITION_WIDTH-1:0] pos_z,
   output logic signed [15:0]               front_x,
   output logic signed [15:0]               front_y,
   output logic signed [15:0]               front_z,
   output logic signed [15:0]               heading,
   output logic signed [14:0]               tilt
);

   localparam int PW = POSITION_WIDTH;
   // half a turn plus 92 full turns: makes any biased heading sum positive
   localparam logic signed [24:0] HEAD_BIAS = 25'sd4262400;

   logic [15:0]        sens_ff, speed_ff;
   logic signed [23:0] hsum_ff, tsum_ff;
   logic signed [15:0] head_ff, head_in;
   logic signed [14:0] tilt_ff, tilt_in;
   logic [5:0]         held_ff;
   logic signed [PW-1:0] pos_ff [3];
   logic signed [15:0] front_ff [3];
   logic signed [15:0] rx_ff, rz_ff;
   logic signed [33:0] cx_ff, cy_ff;
   logic signed [23:0] cz_ff;
   logic               cneg_ff;
   logic signed [15:0] sh_ff, ch_ff, st_ff, ct_ff;
   logic signed [24:0] vel_ff;
   logic signed [41:0] step_ff;

   // Angle step: scale the offsets and add them to the current angles
   logic signed [32:0] hp, tp;
   logic signed [23:0] hs, ts;
   logic signed [23:0] hsum, tsum;
   always_comb begin
      hp   = req_look_dx * $signed({1'b0, sens_ff});
      tp   = req_look_dy * $signed({1'b0, sens_ff});
      hs   = 24'((hp + 33'sd256) >>> 9);
      ts   = 24'((tp + 33'sd256) >>> 9);
      hsum = 24'(head_ff) + hs;
      tsum = 24'(tilt_ff) + ts;
   end

   // Wrap heading: bias positive, keep the low 10 bits, reduce the rest mod 45
   logic signed [24:0] hbias;
   logic [13:0]        hq;
   logic [28:0]        hprod;
   logic [7:0]         hdiv;
   logic [5:0]         hrem;
   logic [16:0]        hfold;
   always_comb begin
      hbias = 25'(hsum_ff) + HEAD_BIAS;
      hq    = hbias[23:10];
      // quotient by 45 through a reciprocal multiply
      hprod = 29'(hq) * 29'd23302;
      hdiv  = hprod[27:20];
      hrem  = 6'(hq - 14'(hdiv) * 14'd45);
      hfold = 17'({hrem, hbias[9:0]});
      head_in = 16'($signed(hfold) - 17'sd23040);
      if (tsum_ff > 24'(TILT_LIMIT)) begin
         tilt_in = 15'(TILT_LIMIT);
      end else if (tsum_ff < -24'(TILT_LIMIT)) begin
         tilt_in = 15'(-TILT_LIMIT);
      end else begin
         tilt_in = 15'(tsum_ff);
      end
   end

   // CORDIC setup and rounds
   logic signed [16:0] ang, ang_red;
   logic               neg_red;
   logic signed [33:0] sx, sy;
   logic signed [22:0] at;
   logic signed [17:0] rnd_x, rnd_y;
   logic signed [15:0] fin_x, fin_y;
   always_comb begin
      ang     = ctl.sel_tilt ? 17'(tilt_ff) : 17'(head_ff);
      ang_red = ang;
      neg_red = 1'b0;
      if (ang > 17'sd11520) begin
         ang_red = ang - 17'(HEAD_HALF);
         neg_red = 1'b1;
      end else if (ang < -17'sd11520) begin
         ang_red = ang + 17'(HEAD_HALF);
         neg_red = 1'b1;
      end
      sx = cy_ff >>> ctl.iter;
      sy = cx_ff >>> ctl.iter;
      at = atan_lookup(ctl.iter);
      rnd_x = 18'((cx_ff + 34'sd32768) >>> 16);
      rnd_y = 18'((cy_ff + 34'sd32768) >>> 16);
      fin_x = (rnd_x > 18'(UNIT_Q14)) ? UNIT_Q14 :
              (rnd_x < -18'(UNIT_Q14)) ? -UNIT_Q14 : 16'(rnd_x);
      fin_y = (rnd_y > 18'(UNIT_Q14)) ? UNIT_Q14 :
              (rnd_y < -18'(UNIT_Q14)) ? -UNIT_Q14 : 16'(rnd_y);
      if (cneg_ff) begin
         fin_x = -fin_x;
         fin_y = -fin_y;
      end
   end

   // Front vector products
   function automatic logic signed [15:0] mul_q14(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
      logic signed [31:0] p;
      logic signed [17:0] r;
      p = a * b;
      r = 18'((p + 32'sd8192) >>> 14);
      if (r > 18'(UNIT_Q14)) return UNIT_Q14;
      if (r < -18'(UNIT_Q14)) return -UNIT_Q14;
      return 16'(r);
   endfunction

   // Movement: component times velocity, then saturating add
   logic signed [15:0] comp;
   logic signed [15:0] comp_x, comp_y, comp_z;
   logic               dneg;
   logic signed [PW+1:0] addend, psum;
   logic signed [PW-1:0] pmax, pmin, pnew, pcur;
   always_comb begin
      comp_x = 16'sd0;
      comp_y = 16'sd0;
      comp_z = 16'sd0;
      dneg   = 1'b0;
      case (ctl.dir)
         3'd0, 3'd1: begin
            comp_x = rx_ff;
            comp_z = rz_ff;
            dneg   = (ctl.dir == 3'd0);
         end
         3'd2, 3'd3: begin
            comp_y = UNIT_Q14;
            dneg   = (ctl.dir == 3'd2);
         end
         default: begin
            comp_x = front_ff[0];
            comp_y = front_ff[1];
            comp_z = front_ff[2];
            dneg   = (ctl.dir == 3'd5);
         end
      endcase
      case (ctl.axis)
         2'd0:    comp = comp_x;
         2'd1:    comp = comp_y;
         default: comp = comp_z;
      endcase
      pmax = {1'b0, {(PW-1){1'b1}}};
      pmin = {1'b1, {(PW-1){1'b0}}};
      pcur = pos_ff[ctl.axis];
      // step fits in 29 bits; extend both sides safely
      if (PW + 2 >= 42) begin
         addend = (PW+2)'(step_ff);
      end else begin
         addend = (step_ff > 42'((PW+2)'(pmax)) + 42'sd1) ? (PW+2)'(pmax) + 1'b1 :
                  (step_ff < 42'(pmin) - 42'sd1) ? (PW+2)'(pmin) - 1'b1 :
                  (PW+2)'(step_ff);
      end
      if (dneg) addend = -addend;
      psum = (PW+2)'(pcur) + addend;
      if (psum > (PW+2)'(pmax)) pnew = pmax;
      else if (psum < (PW+2)'(pmin)) pnew = pmin;
      else pnew = PW'(psum);
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff  <= SENS_RESET;
         speed_ff <= SPEED_RESET;
      end else if (csr_write && csr_index_ok) begin
         if (csr_index == CSR_SENS) sens_ff <= csr_data;
         else speed_ff <= csr_data;
      end
   end

   // Item capture: angle sums before wrap and clamp
   always_ff @(posedge clock) begin
      if (ctl.cmd == CMD_LOAD) begin
         hsum_ff <= hsum;
         tsum_ff <= tsum;
      end
   end

   // Architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 16'sd0;
         tilt_ff  <= 15'sd0;
         held_ff  <= 6'd0;
         pos_ff[0] <= '0;
         pos_ff[1] <= '0;
         pos_ff[2] <= '0;
         front_ff[0] <= UNIT_Q14;
         front_ff[1] <= 16'sd0;
         front_ff[2] <= 16'sd0;
         rx_ff <= 16'sd0;
         rz_ff <= UNIT_Q14;
      end else begin
         if (ctl.cmd == CMD_LOAD && req_op == OP_KEY && req_direction_index < 3'd6) begin
            held_ff[req_direction_index] <= req_key_down;
         end
         if (ctl.cmd == CMD_ANGLE) begin
            head_ff <= head_in;
            tilt_ff <= tilt_in;
         end
         if (ctl.cmd == CMD_VEC) begin
            front_ff[0] <= mul_q14(ch_ff, ct_ff);
            front_ff[1] <= st_ff;
            front_ff[2] <= mul_q14(sh_ff, ct_ff);
            rx_ff <= -sh_ff;
            rz_ff <= ch_ff;
         end
         if (ctl.cmd == CMD_MOVE && ctl.iter[0]) begin
            pos_ff[ctl.axis] <= pnew;
         end
      end
   end

   // CORDIC and movement working registers
   always_ff @(posedge clock) begin
      if (ctl.cmd == CMD_LOAD) begin
         vel_ff <= 25'(($signed({1'b0, 32'(speed_ff) * 32'(req_delta_time)}) + 33'sd128)
                       >>> 8);
      end
      if (ctl.cmd == CMD_CINIT) begin
         cx_ff   <= CORDIC_START;
         cy_ff   <= 34'sd0;
         cz_ff   <= 24'(ang_red) <<< 9;
         cneg_ff <= neg_red;
      end
      if (ctl.cmd == CMD_CITER) begin
         if (cz_ff >= 0) begin
            cx_ff <= cx_ff - sx;
            cy_ff <= cy_ff + sy;
            cz_ff <= cz_ff - 24'(at);
         end else begin
            cx_ff <= cx_ff + sx;
            cy_ff <= cy_ff - sy;
            cz_ff <= cz_ff + 24'(at);
         end
      end
      if (ctl.cmd == CMD_CDONE) begin
         if (ctl.sel_tilt) begin
            st_ff <= fin_y;
            ct_ff <= fin_x;
         end else begin
            sh_ff <= fin_y;
            ch_ff <= fin_x;
         end
      end
      if (ctl.cmd == CMD_MOVE && !ctl.iter[0]) begin
         step_ff <= 42'((42'(comp) * 42'(vel_ff) + 42'sd8192) >>> 14);
      end
   end

   assign held    = held_ff;
   assign pos_x   = pos_ff[0];
   assign pos_y   = pos_ff[1];
   assign pos_z   = pos_ff[2];
   assign front_x = front_ff[0];
   assign front_y = front_ff[1];
   assign front_z = front_ff[2];
   assign heading = head_ff;
   assign tilt    = tilt_ff;

endmodule
